@@ rtl/swhs_pkg.sv @@
// Shared types and constants for the single-wire humidity sensor reader.
package swhs_pkg;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_TYPE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_LOW     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_WAIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESP_TIMEOUT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_LOW_TO    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_HIGH_TO   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_THRESHOLD = 3'd6;

    // Reset values of the configuration registers
    localparam logic        RST_SENSOR_TYPE   = 1'b1;
    localparam logic [15:0] RST_START_LOW     = 16'd20000;
    localparam logic [7:0]  RST_RELEASE_WAIT  = 8'd30;
    localparam logic [7:0]  RST_RESP_TIMEOUT  = 8'd100;
    localparam logic [7:0]  RST_BIT_LOW_TO    = 8'd80;
    localparam logic [7:0]  RST_BIT_HIGH_TO   = 8'd100;
    localparam logic [7:0]  RST_ONE_THRESHOLD = 8'd40;

    localparam logic       SENSOR_DHT11 = 1'b0;
    localparam logic       CMD_TICK     = 1'b0;
    localparam logic [5:0] NUM_BITS     = 6'd40;
    localparam logic [15:0] DHT11_SCALE = 16'd10;
    localparam logic [7:0] MAG_MASK     = 8'h7F;
    localparam logic [7:0] SIGN_MASK    = 8'h80;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_RELEASE   = 3'd2,
        PH_RESP_LOW  = 3'd3,
        PH_RESP_HIGH = 3'd4,
        PH_RESP_END  = 3'd5,
        PH_BIT_LOW   = 3'd6,
        PH_BIT_HIGH  = 3'd7
    } phase_t;

    typedef struct packed {
        logic        sensor_type;
        logic [15:0] start_low_us;
        logic [7:0]  release_wait_us;
        logic [7:0]  response_timeout_us;
        logic [7:0]  bit_low_timeout_us;
        logic [7:0]  bit_high_timeout_us;
        logic [7:0]  one_threshold_us;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] humidity_tenths;
        logic [15:0] temperature_tenths;
    } frame_res_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] humidity_tenths;
        logic [15:0] temperature_tenths;
    } out_item_t;

endpackage

@@ rtl/swhs_decode.sv @@
// Frame checker and decoder: byte-sum checksum and humidity/temperature in tenths.
module swhs_decode
    import swhs_pkg::*;
(
    input  logic [39:0] frame,
    input  logic        sensor_type,
    output frame_res_t  res
);

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic [15:0] mag;

    assign b0  = frame[39:32];
    assign b1  = frame[31:24];
    assign b2  = frame[23:16];
    assign b3  = frame[15:8];
    assign b4  = frame[7:0];
    assign sum = b0 + b1 + b2 + b3;
    assign mag = {b2 & MAG_MASK, b3};

    always_comb
    begin
        res = '0;
        if (sum != b4)
        begin
            res.status = ST_CHECKSUM;
        end
        else if (sensor_type == SENSOR_DHT11)
        begin
            res.humidity_tenths    = {8'd0, b0} * DHT11_SCALE + {8'd0, b1};
            res.temperature_tenths = {8'd0, b2} * DHT11_SCALE + {8'd0, b3};
        end
        else
        begin
            res.humidity_tenths    = {b0, b1};
            // sign-magnitude to two's complement
            res.temperature_tenths = ((b2 & SIGN_MASK) != 8'd0) ? (16'd0 - mag) : mag;
        end
    end

endmodule

@@ rtl/swhs_seq.sv @@
// Protocol sequencer: phase, elapsed timer, bit counter and frame shifter.
module swhs_seq
    import swhs_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic      cmd,
    input  logic      line_level,
    input  cfg_t      cfg,
    output out_item_t item
);

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [5:0]             bit_reg, bit_next;
    logic [39:0]            frame_reg, frame_next;

    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [TIMER_WIDTH-1:0] start_ext, release_ext, limit_ext, thresh_ext;
    logic [7:0]             limit;
    logic                   want_level;
    logic                   bit_one;
    logic [39:0]            frame_shifted;
    logic [5:0]             bit_inc;
    frame_res_t             dec;

    assign timer_inc     = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 1'b1;
    assign start_ext     = TIMER_WIDTH'(cfg.start_low_us);
    assign release_ext   = TIMER_WIDTH'(cfg.release_wait_us);
    assign limit_ext     = TIMER_WIDTH'(limit);
    assign thresh_ext    = TIMER_WIDTH'(cfg.one_threshold_us);
    assign bit_one       = timer_reg > thresh_ext;
    assign frame_shifted = {frame_reg[38:0], bit_one};
    assign bit_inc       = bit_reg + 1'b1;
    assign want_level    = (phase_reg == PH_RESP_HIGH) || (phase_reg == PH_BIT_LOW);

    always_comb
    begin
        case (phase_reg)
            PH_BIT_LOW:  limit = cfg.bit_low_timeout_us;
            PH_BIT_HIGH: limit = cfg.bit_high_timeout_us;
            default:     limit = cfg.response_timeout_us;
        endcase
    end

    swhs_decode u_decode (
        .frame       (frame_shifted),
        .sensor_type (cfg.sensor_type),
        .res         (dec)
    );

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        frame_next = frame_reg;
        item       = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (cmd != CMD_TICK)
                begin
                    phase_next = PH_START;
                    timer_next = '0;
                    bit_next   = '0;
                    frame_next = '0;
                end
            end
            PH_START, PH_RELEASE:
            begin
                timer_next = timer_inc;
                if (timer_inc >= ((phase_reg == PH_START) ? start_ext : release_ext))
                begin
                    phase_next = (phase_reg == PH_START) ? PH_RELEASE : PH_RESP_LOW;
                    timer_next = '0;
                end
            end
            PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_END, PH_BIT_LOW, PH_BIT_HIGH:
            begin
                if (line_level == want_level)
                begin
                    timer_next = '0;
                    case (phase_reg)
                        PH_RESP_LOW:  phase_next = PH_RESP_HIGH;
                        PH_RESP_HIGH: phase_next = PH_RESP_END;
                        PH_RESP_END:  phase_next = PH_BIT_LOW;
                        PH_BIT_LOW:   phase_next = PH_BIT_HIGH;
                        default:
                        begin
                            frame_next = frame_shifted;
                            bit_next   = bit_inc;
                            if (bit_inc >= NUM_BITS)
                            begin
                                phase_next              = PH_IDLE;
                                item.done_res           = 1'b1;
                                item.status             = dec.status;
                                item.humidity_tenths    = dec.humidity_tenths;
                                item.temperature_tenths = dec.temperature_tenths;
                            end
                            else
                            begin
                                phase_next = PH_BIT_LOW;
                            end
                        end
                    endcase
                end
                else
                begin
                    timer_next = timer_inc;
                    if (timer_inc > limit_ext)
                    begin
                        phase_next    = PH_IDLE;
                        item.done_res = 1'b1;
                        item.status   = ST_TIMEOUT;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
        item.drive_low = (phase_next == PH_START);
        item.busy_res  = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bit_reg   <= '0;
            frame_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            frame_reg <= frame_next;
        end
    end

endmodule

@@ rtl/single_wire_humidity_sensor_reader.sv @@
// Single-wire humidity sensor reader top level: config registers, sequencer, result register.
//
// Reader for DHT11 / DHT22 / AM2301 style single-wire sensors. Every input word
// is either a one-microsecond tick carrying the sampled line level (s_tuser = 0)
// or a start command (s_tuser = 1); every accepted word yields exactly one result
// word. On start the block asks for the line to be pulled low for start_low_us
// ticks, releases it for release_wait_us ticks, follows the sensor response
// (low, high, low) and then 40 data bits, each a low part and a high pulse; a
// high pulse longer than one_threshold_us is a one. Each wait fails with timeout
// status once its elapsed count exceeds its limit. At the end of the frame the
// byte-sum checksum is checked and humidity and temperature are reported in
// tenths (DHT11 integer+tenth bytes or DHT22 16-bit sign-magnitude). A start
// while a reading is running counts as an ordinary tick. Throughput is one word
// per clock unless the receiver holds m_tready low: the sequencer state and the
// decode are updated in the cycle a word is accepted and the result lands in a
// single output register, which is refilled in the same cycle it is taken. The
// result is valid in the cycle after acceptance. Configuration writes are taken
// at any time but belong in idle periods.
module single_wire_humidity_sensor_reader
    import swhs_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] line_level, [7:1] zero
    input  logic                   s_tuser,   // [0] cmd
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
    // [20:5] humidity_tenths, [36:21] temperature_tenths, [39:37] zero
    output logic [39:0]            m_tdata,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg_reg;
    out_item_t item_next;
    out_item_t item_reg;
    logic      valid_reg;
    logic      accept;

    // Hold config; writes past the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_type         <= RST_SENSOR_TYPE;
            cfg_reg.start_low_us        <= RST_START_LOW;
            cfg_reg.release_wait_us     <= RST_RELEASE_WAIT;
            cfg_reg.response_timeout_us <= RST_RESP_TIMEOUT;
            cfg_reg.bit_low_timeout_us  <= RST_BIT_LOW_TO;
            cfg_reg.bit_high_timeout_us <= RST_BIT_HIGH_TO;
            cfg_reg.one_threshold_us    <= RST_ONE_THRESHOLD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SENSOR_TYPE:   cfg_reg.sensor_type         <= cfg_data[0];
                REG_START_LOW:     cfg_reg.start_low_us        <= cfg_data;
                REG_RELEASE_WAIT:  cfg_reg.release_wait_us     <= cfg_data[7:0];
                REG_RESP_TIMEOUT:  cfg_reg.response_timeout_us <= cfg_data[7:0];
                REG_BIT_LOW_TO:    cfg_reg.bit_low_timeout_us  <= cfg_data[7:0];
                REG_BIT_HIGH_TO:   cfg_reg.bit_high_timeout_us <= cfg_data[7:0];
                REG_ONE_THRESHOLD: cfg_reg.one_threshold_us    <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // Accept a new word whenever the result register is empty or being drained.
    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    swhs_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .cmd        (s_tuser),
        .line_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .item       (item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload register: load on accept, hold while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0, item_reg.temperature_tenths, item_reg.humidity_tenths,
                       item_reg.status, item_reg.done_res, item_reg.busy_res,
                       item_reg.drive_low};

    // The line is only driven during a reading.
    a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(item_reg.drive_low && !item_reg.busy_res))
        else $error("drive_low without busy");

    // A finished reading leaves the block idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && item_reg.done_res) |-> !item_reg.busy_res)
        else $error("done with busy still set");

    // Status only reports alongside done, and only known codes.
    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((item_reg.status == ST_OK) ||
                       (item_reg.done_res &&
                        ((item_reg.status == ST_TIMEOUT) || (item_reg.status == ST_CHECKSUM)))))
        else $error("bad status or status without done");

    // Measurements are zero unless a reading finished cleanly.
    a_values_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !(item_reg.done_res && (item_reg.status == ST_OK))) |->
        ((item_reg.humidity_tenths == 16'd0) && (item_reg.temperature_tenths == 16'd0)))
        else $error("measurement without successful reading");

endmodule

@@ dv/single_wire_humidity_sensor_reader_tb.sv @@
// Self-checking testbench for the single-wire humidity sensor reader.
`timescale 1ns / 100ps

module single_wire_humidity_sensor_reader_tb
    import swhs_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          MAX_REPORTS  = 10;
    localparam int          RANDOM_WORDS = 300;
    localparam logic        CMD_START    = 1'b1;
    localparam logic [15:0] TIMER_MAX    = 16'hFFFF;

    // Wait numbering used to break a reading on purpose: the three response
    // waits come first, then a low wait and a high wait for each data bit.
    localparam int NO_SPOIL       = -1;
    localparam int SPOIL_RESP_LOW = 0;
    localparam int SPOIL_RESP_END = 2;
    localparam int FIRST_BIT_WAIT = 3;
    localparam int LAST_WAIT      = FIRST_BIT_WAIT + 2 * 40 - 1;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [0] line_level, [7:1] zero
    logic                   s_tuser;   // [0] cmd
    logic                   m_tvalid;
    logic                   m_tready;
    // [0] drive_low, [1] busy_res, [2] done_res, [4:3] status,
    // [20:5] humidity_tenths, [36:21] temperature_tenths, [39:37] zero
    logic [39:0]            m_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicted reader state and its copy of the register file
    cfg_t        rd_cfg;
    phase_t      rd_phase;
    logic [15:0] rd_timer;
    logic [5:0]  rd_bits;
    logic [39:0] rd_frame;

    out_item_t   pending_readouts[$];
    int          errors;
    int          n_words;
    int unsigned cycle_count;
    bit          gaps_on;

    single_wire_humidity_sensor_reader u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Reader prediction
    // ------------------------------------------------------------------

    function automatic void reader_reset();
        rd_cfg.sensor_type         = RST_SENSOR_TYPE;
        rd_cfg.start_low_us        = RST_START_LOW;
        rd_cfg.release_wait_us     = RST_RELEASE_WAIT;
        rd_cfg.response_timeout_us = RST_RESP_TIMEOUT;
        rd_cfg.bit_low_timeout_us  = RST_BIT_LOW_TO;
        rd_cfg.bit_high_timeout_us = RST_BIT_HIGH_TO;
        rd_cfg.one_threshold_us    = RST_ONE_THRESHOLD;
        rd_phase = PH_IDLE;
        rd_timer = '0;
        rd_bits  = '0;
        rd_frame = '0;
    endfunction

    // Count one microsecond, holding at the top of the timer.
    function automatic void timer_tick();
        if (rd_timer != TIMER_MAX)
            rd_timer = rd_timer + 16'd1;
    endfunction

    // 1 = awaited level seen, -1 = limit exceeded, 0 = keep waiting
    function automatic int await_level(logic lvl, logic want, logic [7:0] limit);
        if (lvl == want)
            return 1;
        timer_tick();
        return (rd_timer > limit) ? -1 : 0;
    endfunction

    // Advance the predicted reader by one accepted word; return its readout.
    function automatic out_item_t advance_reader(logic cmd, logic lvl);
        out_item_t   res;
        logic [15:0] high_time;
        logic [15:0] mag;
        logic [7:0]  b0, b1, b2, b3, b4, sum;
        int          got;
        res = '0;
        case (rd_phase)
            PH_IDLE:
                if (cmd != CMD_TICK)
                begin
                    rd_phase = PH_START;
                    rd_timer = '0;
                    rd_bits  = '0;
                    rd_frame = '0;
                end
            PH_START:
            begin
                timer_tick();
                if (rd_timer >= rd_cfg.start_low_us)
                begin
                    rd_phase = PH_RELEASE;
                    rd_timer = '0;
                end
            end
            PH_RELEASE:
            begin
                timer_tick();
                if (rd_timer >= rd_cfg.release_wait_us)
                begin
                    rd_phase = PH_RESP_LOW;
                    rd_timer = '0;
                end
            end
            PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_END:
            begin
                got = await_level(lvl, rd_phase == PH_RESP_HIGH,
                                  rd_cfg.response_timeout_us);
                if (got < 0)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_TIMEOUT;
                    rd_phase     = PH_IDLE;
                end
                else if (got > 0)
                begin
                    rd_timer = '0;
                    case (rd_phase)
                        PH_RESP_LOW:  rd_phase = PH_RESP_HIGH;
                        PH_RESP_HIGH: rd_phase = PH_RESP_END;
                        default:      rd_phase = PH_BIT_LOW;
                    endcase
                end
            end
            PH_BIT_LOW:
            begin
                got = await_level(lvl, 1'b1, rd_cfg.bit_low_timeout_us);
                if (got < 0)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_TIMEOUT;
                    rd_phase     = PH_IDLE;
                end
                else if (got > 0)
                begin
                    rd_phase = PH_BIT_HIGH;
                    rd_timer = '0;
                end
            end
            PH_BIT_HIGH:
            begin
                high_time = rd_timer;
                got = await_level(lvl, 1'b0, rd_cfg.bit_high_timeout_us);
                if (got < 0)
                begin
                    res.done_res = 1'b1;
                    res.status   = ST_TIMEOUT;
                    rd_phase     = PH_IDLE;
                end
                else if (got > 0)
                begin
                    // first bit in ends up as the MSB of byte 0
                    rd_frame = {rd_frame[38:0], high_time > rd_cfg.one_threshold_us};
                    rd_bits  = rd_bits + 6'd1;
                    rd_timer = '0;
                    if (rd_bits >= NUM_BITS)
                    begin
                        {b0, b1, b2, b3, b4} = rd_frame;
                        sum = b0 + b1 + b2 + b3;
                        res.done_res = 1'b1;
                        rd_phase = PH_IDLE;
                        if (sum != b4)
                            res.status = ST_CHECKSUM;
                        else if (rd_cfg.sensor_type == SENSOR_DHT11)
                        begin
                            // integer byte plus tenth byte, no sign
                            res.humidity_tenths    = b0 * DHT11_SCALE + b1;
                            res.temperature_tenths = b2 * DHT11_SCALE + b3;
                        end
                        else
                        begin
                            // 16-bit tenths, temperature in sign-magnitude
                            mag = {b2 & MAG_MASK, b3};
                            res.humidity_tenths    = {b0, b1};
                            res.temperature_tenths = ((b2 & SIGN_MASK) != 8'd0) ?
                                                     16'd0 - mag : mag;
                        end
                    end
                    else
                        rd_phase = PH_BIT_LOW;
                end
            end
            default:
                rd_phase = PH_IDLE;
        endcase
        res.drive_low = (rd_phase == PH_START);
        res.busy_res  = (rd_phase != PH_IDLE);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_readout();
        out_item_t want;
        out_item_t got;
        got.drive_low          = m_tdata[0];
        got.busy_res           = m_tdata[1];
        got.done_res           = m_tdata[2];
        got.status             = m_tdata[4:3];
        got.humidity_tenths    = m_tdata[20:5];
        got.temperature_tenths = m_tdata[36:21];
        if (pending_readouts.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR: result word %h with no readout pending", m_tdata);
        end
        else
        begin
            want = pending_readouts.pop_front();
            if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.status !== want.status ||
                got.humidity_tenths !== want.humidity_tenths ||
                got.temperature_tenths !== want.temperature_tenths)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("ERROR: cycle %0d exp %b %b %b %0d %0d %0d got %b %b %b %0d %0d %0d",
                             cycle_count, want.drive_low, want.busy_res, want.done_res,
                             want.status, want.humidity_tenths,
                             $signed(want.temperature_tenths), got.drive_low,
                             got.busy_res, got.done_res, got.status,
                             got.humidity_tenths, $signed(got.temperature_tenths));
            end
        end
    endtask

    // Sample every taken result word at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_readout();
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short pauses, a few long ones.
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int cap(int a, int b);
        return (a < b) ? a : b;
    endfunction

    // During a reading a start counts as a tick; slip one in now and then.
    function automatic logic busy_cmd();
        return ($urandom_range(0, 39) == 0) ? CMD_START : CMD_TICK;
    endfunction

    function automatic logic [39:0] make_frame(logic [7:0] b0, logic [7:0] b1,
                                               logic [7:0] b2, logic [7:0] b3,
                                               logic good);
        logic [7:0] sum;
        sum = b0 + b1 + b2 + b3;
        if (!good)
            sum = sum + 8'($urandom_range(1, 255));
        return {b0, b1, b2, b3, sum};
    endfunction

    // Random payload bytes, with a good or a broken checksum.
    function automatic logic [39:0] rand_frame(logic good);
        return make_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), good);
    endfunction

    // Receiver side: hold ready for a while, then drop it for a random gap.
    initial
    begin
        int n;
        m_tready = 1'b0;
        forever
        begin
            n = pick_gap();
            @(negedge clk);
            if (n > 0)
            begin
                m_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
    end

    // Offer one word, wait for it to be taken, then record its readout.
    task automatic send_word(logic cmd, logic lvl);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {7'd0, lvl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_readouts.push_back(advance_reader(cmd, lvl));
        n_words++;
    endtask

    // Stop sending and let every pending readout come back.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (idx)
            REG_SENSOR_TYPE:   rd_cfg.sensor_type         = value[0];
            REG_START_LOW:     rd_cfg.start_low_us        = value;
            REG_RELEASE_WAIT:  rd_cfg.release_wait_us     = value[7:0];
            REG_RESP_TIMEOUT:  rd_cfg.response_timeout_us = value[7:0];
            REG_BIT_LOW_TO:    rd_cfg.bit_low_timeout_us  = value[7:0];
            REG_BIT_HIGH_TO:   rd_cfg.bit_high_timeout_us = value[7:0];
            REG_ONE_THRESHOLD: rd_cfg.one_threshold_us    = value[7:0];
            default: ;
        endcase
    endtask

    // Program the whole register file once the reader has gone quiet.
    task automatic program_timing(logic kind, logic [15:0] start_low, logic [7:0] rel,
                                  logic [7:0] resp, logic [7:0] blo, logic [7:0] bhi,
                                  logic [7:0] thr);
        drain_results();
        write_reg(REG_SENSOR_TYPE, {15'd0, kind});
        write_reg(REG_START_LOW, start_low);
        write_reg(REG_RELEASE_WAIT, {8'd0, rel});
        write_reg(REG_RESP_TIMEOUT, {8'd0, resp});
        write_reg(REG_BIT_LOW_TO, {8'd0, blo});
        write_reg(REG_BIT_HIGH_TO, {8'd0, bhi});
        write_reg(REG_ONE_THRESHOLD, {8'd0, thr});
    endtask

    // Hold the line off the awaited level for k ticks, then move to it.
    // Skip whatever is left once the reading has ended.
    task automatic wait_level(logic awaited, int k);
        int i;
        for (i = 0; i < k && rd_phase != PH_IDLE; i++)
            send_word(busy_cmd(), !awaited);
        if (rd_phase != PH_IDLE)
        begin
            // now and then hold off mid-reading until every readout is back
            if (gaps_on && $urandom_range(0, 149) == 0)
                drain_results();
            send_word(busy_cmd(), awaited);
        end
    endtask

    // Play the sensor side of one reading; time out at wait 'spoil' if asked.
    task automatic run_reading(logic [39:0] frame, int spoil);
        int   w;
        int   k;
        int   thr;
        int   bhi;
        int   blo;
        int   resp;
        logic bit_v;
        thr  = int'(rd_cfg.one_threshold_us);
        bhi  = int'(rd_cfg.bit_high_timeout_us);
        blo  = int'(rd_cfg.bit_low_timeout_us);
        resp = int'(rd_cfg.response_timeout_us);
        send_word(CMD_START, 1'($urandom_range(0, 1)));
        // line level is ignored while pulling low and while released
        while (rd_phase == PH_START || rd_phase == PH_RELEASE)
            send_word(busy_cmd(), 1'($urandom_range(0, 1)));
        for (w = 0; w < FIRST_BIT_WAIT; w++)
        begin
            k = (spoil == w) ? resp + 1 : $urandom_range(0, cap(resp, 6));
            wait_level(w == 1, k);
        end
        for (w = 0; w < 40; w++)
        begin
            k = (spoil == FIRST_BIT_WAIT + 2 * w) ? blo + 1 : $urandom_range(0, cap(blo, 1));
            wait_level(1'b1, k);
            bit_v = frame[39 - w];
            if (spoil == FIRST_BIT_WAIT + 2 * w + 1)
                k = bhi + 1;
            else
            begin
                // pulse widths cluster around the threshold on both sides
                if (bit_v)
                    k = $urandom_range(thr + 1, thr + 3);
                else
                    k = $urandom_range((thr > 3) ? thr - 3 : 0, thr);
                k = cap(k, bhi);
            end
            wait_level(1'b0, k);
        end
    endtask

    // Hold the line at the wrong level until the reading gives up.
    task automatic finish_reading();
        while (rd_phase != PH_IDLE)
        begin
            case (rd_phase)
                PH_RESP_HIGH, PH_BIT_LOW:             send_word(CMD_TICK, 1'b0);
                PH_RESP_LOW, PH_RESP_END, PH_BIT_HIGH: send_word(CMD_TICK, 1'b1);
                default: send_word(CMD_TICK, 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: pull low under the default start time, then cut the start
    // time short so the default release wait and response limit run out.
    task automatic test_reset_defaults();
        gaps_on = 1'b0;
        send_word(CMD_START, 1'b1);
        repeat (6) send_word(busy_cmd(), 1'($urandom_range(0, 1)));
        drain_results();
        write_reg(REG_START_LOW, 16'd4);
        finish_reading();
        gaps_on = 1'b1;
    endtask

    task automatic test_register_extremes();
        // longest start pulse held for a while and then cut short; longest
        // release, all limits zero
        gaps_on = 1'b0;
        program_timing(1'b1, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(CMD_START, 1'b0);
        repeat (8) send_word(busy_cmd(), 1'($urandom_range(0, 1)));
        drain_results();
        write_reg(REG_START_LOW, 16'd1);
        finish_reading();
        // zero start and release; widest response limit exceeded at the last
        // response wait
        gaps_on = 1'b1;
        program_timing(1'b0, 16'h0000, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_reading(rand_frame(1'b1), SPOIL_RESP_END);
        program_timing(1'b1, 16'h0001, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        run_reading(make_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1), NO_SPOIL);
    endtask

    task automatic test_decode_cases();
        program_timing(1'b1, 16'd2, 8'd1, 8'd8, 8'd6, 8'd8, 8'd0);
        run_reading(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), NO_SPOIL); // sum wraps
        run_reading(make_frame(8'h01, 8'hF4, 8'h80, 8'h00, 1'b1), NO_SPOIL); // minus zero
        run_reading(make_frame(8'h00, 8'h00, 8'h7F, 8'hFF, 1'b1), NO_SPOIL); // top positive
        run_reading(make_frame(8'h02, 8'h8C, 8'h01, 8'h5F, 1'b0), NO_SPOIL); // bad sum
        program_timing(1'b0, 16'd1, 8'd2, 8'd8, 8'd6, 8'd8, 8'd1);
        run_reading(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), NO_SPOIL);
        run_reading(make_frame(8'h32, 8'h05, 8'h96, 8'h09, 1'b1), NO_SPOIL); // no sign
        run_reading(make_frame(8'h40, 8'h00, 8'h19, 8'h03, 1'b0), NO_SPOIL);
    endtask

    task automatic test_timeouts();
        int w;
        // zero limits: one tick at the wrong level is already too long
        program_timing(1'b1, 16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        for (w = SPOIL_RESP_LOW; w <= FIRST_BIT_WAIT + 1; w++)
            run_reading(rand_frame(1'b1), w);
        program_timing(1'b0, 16'd2, 8'd2, 8'd5, 8'd4, 8'd6, 8'd2);
        for (w = SPOIL_RESP_LOW; w <= SPOIL_RESP_END; w++)
            run_reading(rand_frame(1'b1), w);
        run_reading(rand_frame(1'b1), FIRST_BIT_WAIT + 2 * $urandom_range(0, 39));
        run_reading(rand_frame(1'b1), FIRST_BIT_WAIT + 2 * $urandom_range(0, 39) + 1);
        run_reading(rand_frame(1'b1), LAST_WAIT);
    endtask

    task automatic test_idle_and_restart();
        program_timing(1'b1, 16'd3, 8'd2, 8'd10, 8'd10, 8'd10, 8'd2);
        // ticks while idle change nothing
        send_word(CMD_TICK, 1'b0);
        send_word(CMD_TICK, 1'b1);
        // a second and third start while pulling low are plain ticks
        send_word(CMD_START, 1'b1);
        send_word(CMD_START, 1'b0);
        send_word(CMD_START, 1'b1);
        finish_reading();
        // restart right after a failed reading, no pause in between
        run_reading(rand_frame(1'b1), NO_SPOIL);
    endtask

    task automatic random_timing();
        program_timing(1'($urandom_range(0, 1)),
                       16'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                       : $urandom_range(0, 4)),
                       8'($urandom_range(0, 4)),
                       8'(($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 12)),
                       8'(($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 6)),
                       8'($urandom_range(4, 10)),
                       8'($urandom_range(0, 3)));
    endtask

    task automatic test_random_readings();
        int   first;
        int   spoil;
        int   noise;
        first = n_words;
        while (n_words - first < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 2) == 0)
                random_timing();
            // runs of readings with no idling on either side
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
            begin
                // idle line noise, ignored by the reader
                noise = $urandom_range(1, 4);
                first += noise;
                repeat (noise) send_word(CMD_TICK, 1'($urandom_range(0, 1)));
            end
            spoil = ($urandom_range(0, 9) < 7) ? NO_SPOIL : $urandom_range(0, LAST_WAIT);
            run_reading(rand_frame($urandom_range(0, 7) != 0), spoil);
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_TICK;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        errors      = 0;
        n_words     = 0;
        cycle_count = 0;
        gaps_on     = 1'b1;
        reader_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_decode_cases();
        test_timeouts();
        test_idle_and_restart();
        test_random_readings();

        // let the last readouts arrive, then watch for strays
        drain_results();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_readouts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/swhs_pkg.sv
rtl/swhs_decode.sv
rtl/swhs_seq.sv
rtl/single_wire_humidity_sensor_reader.sv
dv/single_wire_humidity_sensor_reader_tb.sv
